// ===== hdl/stsq_pkg.sv =====
`default_nettype none

package stsq_pkg;

  // queue geometry and limits
  localparam int DEPTH_DEF   = 16;
  localparam int MAX_RESULTS = 16;

  // payload types
  typedef logic [31:0] tick_t;
  typedef logic [7:0]  tid_t;

  // operation codes of an input item
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_SLEEP = 1'b1;

  // result kinds
  typedef enum logic [2:0] {
    KIND_QUEUED  = 3'd0,
    KIND_IGNORED = 3'd1,
    KIND_FULL    = 3'd2,
    KIND_WOKEN   = 3'd3,
    KIND_QUIET   = 3'd4
  } kind_t;

  // control sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/stsq_if.sv =====
`default_nettype none

interface stsq_in_if;
  import stsq_pkg::*;

  logic  valid;
  logic  ready;
  logic  operation;
  tid_t  thread_id;
  tick_t duration;

  modport source (output valid, operation, thread_id, duration, input ready);
  modport sink   (input valid, operation, thread_id, duration, output ready);
endinterface

interface stsq_out_if;
  import stsq_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] kind;
  tid_t       woken_id;
  tick_t      tick_now;
  logic       last;

  modport source (output valid, kind, woken_id, tick_now, last, input ready);
  modport sink   (input valid, kind, woken_id, tick_now, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/sorted_timeout_sleep_queue.sv =====
// channel   dir  handshake            payload
// in_chan   in   valid/ready          operation, thread_id, duration
// out_chan  out  valid/ready          kind, woken_id, tick_now, last
//
// a sleep item with a nonzero duration is inserted into the cell row, unless
// the row is full, in the cycle it is accepted; its single result sits in
// the output register on the next cycle. a tick item advances the counter
// when accepted, then the sequencer gives one result per woken thread, at
// most MAX_RESULTS, or one quiet result; the cell row's head compare decides.
// reset (rst_n, synchronous) clears the counter, occupancy and output valid.
// a stalled output register holds the sequencer; input ready drops meanwhile.
`default_nettype none

module sorted_timeout_sleep_queue #(
  parameter int QUEUE_DEPTH = stsq_pkg::DEPTH_DEF
) (
  input wire           clk,
  input wire           rst_n,
  stsq_in_if.sink      in_chan,
  stsq_out_if.source   out_chan
);
  import stsq_pkg::*;

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  state_t           state_r, state_nxt;
  tick_t            tick_r, tick_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  kind_t            out_kind_r, out_kind_nxt;
  tid_t             out_id_r, out_id_nxt;
  tick_t            out_tick_r, out_tick_nxt;
  logic             out_last_r, out_last_nxt;

  tick_t      cell_dl [QUEUE_DEPTH];
  tid_t       cell_id [QUEUE_DEPTH];
  logic       cell_le [QUEUE_DEPTH];
  cell_ctrl_t ctrl;
  tick_t      ins_dl;

  logic accept, is_sleep, dur_zero, full, do_ins, out_free;
  logic head_due, next_due, do_pop, quiet;

  // input decode
  assign accept   = in_chan.valid && in_chan.ready;
  assign is_sleep = in_chan.operation == OP_SLEEP;
  assign dur_zero = in_chan.duration == '0;
  assign full     = occ_r == OCC_W'(QUEUE_DEPTH);
  assign ins_dl   = tick_r + in_chan.duration;
  assign do_ins   = accept && is_sleep && !dur_zero && !full;
  assign out_free = !out_valid_r || out_chan.ready;

  // head checks against the current tick
  assign head_due = (occ_r != '0) && (cell_dl[0] <= tick_r);
  assign next_due = (occ_r > OCC_W'(1)) && (cell_dl[1] <= tick_r) &&
                    (CNT_W'(cnt_r + 1'b1) < CNT_W'(MAX_RESULTS));
  assign do_pop   = (state_r == ST_POP) && out_free && head_due;
  assign quiet    = (state_r == ST_POP) && out_free && !head_due;

  assign ctrl.ins = do_ins;
  assign ctrl.pop = do_pop;

  // row of cells, head at index zero
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic  prev_le;
    tick_t prev_dl, next_dl;
    tid_t  prev_id, next_id;

    if (i == 0) begin : g_head
      assign prev_le = 1'b1;
      assign prev_dl = '0;
      assign prev_id = '0;
    end else begin : g_mid
      assign prev_le = cell_le[i-1];
      assign prev_dl = cell_dl[i-1];
      assign prev_id = cell_id[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_dl = '0;
      assign next_id = '0;
    end else begin : g_body
      assign next_dl = cell_dl[i+1];
      assign next_id = cell_id[i+1];
    end

    stsq_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .ins_dl  (ins_dl),
      .ins_id  (in_chan.thread_id),
      .valid   (OCC_W'(i) < occ_r),
      .prev_le (prev_le),
      .prev_dl (prev_dl),
      .prev_id (prev_id),
      .next_dl (next_dl),
      .next_id (next_id),
      .dl      (cell_dl[i]),
      .id      (cell_id[i]),
      .le      (cell_le[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !is_sleep) state_nxt = ST_POP;
      end
      ST_POP: begin
        if (out_free && (!head_due || !next_due)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    in_chan.ready = (state_r == ST_IDLE) && out_free;
    tick_nxt      = tick_r;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_chan.ready ? 1'b0 : out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_tick_nxt  = out_tick_r;
    out_last_nxt  = out_last_r;

    if (accept) begin
      cnt_nxt = '0;
      if (is_sleep) begin
        out_valid_nxt = 1'b1;
        out_id_nxt    = '0;
        out_tick_nxt  = tick_r;
        out_last_nxt  = 1'b1;
        if (dur_zero)  out_kind_nxt = KIND_IGNORED;
        else if (full) out_kind_nxt = KIND_FULL;
        else           out_kind_nxt = KIND_QUEUED;
      end else begin
        tick_nxt = tick_r + 1'b1;
      end
    end

    if (do_ins) occ_nxt = occ_r + 1'b1;

    if (do_pop) begin
      occ_nxt       = occ_r - 1'b1;
      cnt_nxt       = cnt_r + 1'b1;
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_WOKEN;
      out_id_nxt    = cell_id[0];
      out_tick_nxt  = tick_r;
      out_last_nxt  = !next_due;
    end else if (quiet) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_QUIET;
      out_id_nxt    = '0;
      out_tick_nxt  = tick_r;
      out_last_nxt  = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      occ_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_tick_r <= out_tick_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.kind     = out_kind_r;
  assign out_chan.woken_id = out_id_r;
  assign out_chan.tick_now = out_tick_r;
  assign out_chan.last     = out_last_r;

`ifndef SYNTHESIS
  // occupancy stays within the cell row
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  // the two head entries stay in deadline order
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r > OCC_W'(1)) |-> (cell_dl[0] <= cell_dl[1]))
    else $error("queue head out of order");

  // wakeups per tick never pass the limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("too many wakeups in one tick");

  // a pop removes exactly one entry
  a_pop_occ: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> (occ_r == $past(occ_r) - 1'b1))
    else $error("pop did not shrink the queue");
`endif

endmodule

`default_nettype wire

// ===== hdl/stsq_cell.sv =====
`default_nettype none

module stsq_cell (
  input  wire                    clk,
  input  stsq_pkg::cell_ctrl_t   ctrl,
  input  stsq_pkg::tick_t        ins_dl,
  input  stsq_pkg::tid_t         ins_id,
  input  wire                    valid,
  input  wire                    prev_le,
  input  stsq_pkg::tick_t        prev_dl,
  input  stsq_pkg::tid_t         prev_id,
  input  stsq_pkg::tick_t        next_dl,
  input  stsq_pkg::tid_t         next_id,
  output stsq_pkg::tick_t        dl,
  output stsq_pkg::tid_t         id,
  output logic                   le
);
  import stsq_pkg::*;

  tick_t dl_r, dl_nxt;
  tid_t  id_r, id_nxt;

  // this entry stays ahead of the new deadline (ties keep arrival order)
  assign le = valid && (dl_r <= ins_dl);

  // insert: keep, take the new entry, or shift in from the left
  // pop: shift in from the right
  always_comb begin
    dl_nxt = dl_r;
    id_nxt = id_r;
    if (ctrl.ins) begin
      if (!le && prev_le) begin
        dl_nxt = ins_dl;
        id_nxt = ins_id;
      end else if (!le) begin
        dl_nxt = prev_dl;
        id_nxt = prev_id;
      end
    end else if (ctrl.pop) begin
      dl_nxt = next_dl;
      id_nxt = next_id;
    end
  end

  always_ff @(posedge clk) begin
    dl_r <= dl_nxt;
    id_r <= id_nxt;
  end

  assign dl = dl_r;
  assign id = id_r;

endmodule

`default_nettype wire

// ===== tb/sorted_timeout_sleep_queue_tb.sv =====
`default_nettype none

module sorted_timeout_sleep_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stsq_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int WATCH_MAX  = 2000;
  localparam int TAIL_ITEMS = 40;
  localparam int HOLD_LEN   = 150;

  // one item for the input channel plus its pressure marks
  typedef struct {
    logic  op;
    tid_t  tid;
    tick_t dur;
    logic  hold_rx;
    logic  drain;
  } sleep_cmd_t;

  // one expected result
  typedef struct {
    kind_t kind;
    tid_t  woken;
    tick_t tick;
    logic  last;
  } timer_result_t;

  logic clk;
  logic rst_n;

  stsq_in_if  in_chan ();
  stsq_out_if out_chan ();

  sorted_timeout_sleep_queue uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sleep_cmd_t    pending[$];
  timer_result_t expected_results[$];

  // shadow copy of the timer queue
  tick_t shadow_tick = '0;
  tick_t shadow_deadline [DEPTH];
  tid_t  shadow_owner [DEPTH];
  int    shadow_count = 0;

  int   err_count = 0;
  int   items_taken = 0;
  int   results_seen = 0;
  int   n_woken = 0;
  int   n_full = 0;
  int   n_ignored = 0;
  int   n_quiet = 0;
  int   n_queued = 0;
  int   peak_wakes = 0;
  logic hold_req;
  int   gap_left;
  sleep_cmd_t cur_item;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  // work out the results of one accepted item and advance the shadow queue
  task automatic predict_timer_step(input sleep_cmd_t it);
    timer_result_t r;
    tick_t due;
    int    pos;
    int    i;
    int    n;
    r.woken = '0;
    r.last  = 1'b1;
    if (it.op == OP_SLEEP) begin
      r.tick = shadow_tick;
      if (it.dur == '0) begin
        r.kind = KIND_IGNORED;
        n_ignored++;
      end else if (shadow_count >= DEPTH) begin
        r.kind = KIND_FULL;
        n_full++;
      end else begin
        // insert behind every entry due at or before the new deadline
        due = shadow_tick + it.dur;
        pos = 0;
        while (pos < shadow_count && shadow_deadline[pos] <= due) pos++;
        for (i = shadow_count; i > pos; i--) begin
          shadow_deadline[i] = shadow_deadline[i-1];
          shadow_owner[i]    = shadow_owner[i-1];
        end
        shadow_deadline[pos] = due;
        shadow_owner[pos]    = it.tid;
        shadow_count++;
        r.kind = KIND_QUEUED;
        n_queued++;
      end
      expected_results.push_back(r);
    end else begin
      shadow_tick = shadow_tick + 1;
      n = 0;
      // pop due heads, at most MAX_RESULTS per tick
      while (n < MAX_RESULTS && shadow_count > 0 && shadow_deadline[0] <= shadow_tick) begin
        r.kind  = KIND_WOKEN;
        r.woken = shadow_owner[0];
        r.tick  = shadow_tick;
        for (i = 1; i < shadow_count; i++) begin
          shadow_deadline[i-1] = shadow_deadline[i];
          shadow_owner[i-1]    = shadow_owner[i];
        end
        shadow_count--;
        n++;
        r.last = (n == MAX_RESULTS) || (shadow_count == 0) ||
                 (shadow_deadline[0] > shadow_tick);
        expected_results.push_back(r);
      end
      if (n == 0) begin
        r.kind  = KIND_QUIET;
        r.woken = '0;
        r.tick  = shadow_tick;
        r.last  = 1'b1;
        expected_results.push_back(r);
        n_quiet++;
      end
      n_woken += n;
      if (n > peak_wakes) peak_wakes = n;
    end
  endtask

  // compare one accepted result with the oldest expectation
  task automatic check_result();
    timer_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: kind %0d id %0d tick %0d",
                                out_chan.kind, out_chan.woken_id, out_chan.tick_now));
      return;
    end
    want = expected_results.pop_front();
    if (out_chan.kind !== want.kind)
      report_mismatch($sformatf("kind %0d, want %0d", out_chan.kind, want.kind));
    if (out_chan.woken_id !== want.woken)
      report_mismatch($sformatf("woken_id %0d, want %0d", out_chan.woken_id, want.woken));
    if (out_chan.tick_now !== want.tick)
      report_mismatch($sformatf("tick_now %0d, want %0d", out_chan.tick_now, want.tick));
    if (out_chan.last !== want.last)
      report_mismatch($sformatf("last %0b, want %0b", out_chan.last, want.last));
  endtask

  function automatic sleep_cmd_t make_sleep(input tid_t tid, input tick_t dur);
    sleep_cmd_t c;
    c.op      = OP_SLEEP;
    c.tid     = tid;
    c.dur     = dur;
    c.hold_rx = 1'b0;
    c.drain   = 1'b0;
    return c;
  endfunction

  function automatic sleep_cmd_t make_tick();
    sleep_cmd_t c;
    c.op      = OP_TICK;
    c.tid     = tid_t'($urandom_range(0, 255));
    c.dur     = tick_t'($urandom);
    c.hold_rx = 1'b0;
    c.drain   = 1'b0;
    return c;
  endfunction

  // input driver: offers pending items with random gaps
  always @(posedge clk) begin : drive_items
    logic took;
    logic offer;
    if (!rst_n) begin
      in_chan.valid     <= 1'b0;
      in_chan.operation <= OP_TICK;
      in_chan.thread_id <= '0;
      in_chan.duration  <= '0;
      hold_req          <= 1'b0;
      gap_left = 0;
    end else begin
      took = in_chan.valid && in_chan.ready;
      if (took) begin
        predict_timer_step(cur_item);
        items_taken++;
      end
      hold_req <= took && cur_item.hold_rx;
      offer = in_chan.valid && !took;
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() != 0 &&
                     !(pending[0].drain && expected_results.size() != 0)) begin
          if (pending.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 17) - 1;
          end else begin
            cur_item = pending.pop_front();
            offer = 1'b1;
            in_chan.operation <= cur_item.op;
            in_chan.thread_id <= cur_item.tid;
            in_chan.duration  <= cur_item.dur;
          end
        end
      end
      in_chan.valid <= offer;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : sink_results
    int   hold_left;
    int   stall_left;
    logic rdy;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      hold_left  = 0;
      stall_left = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        check_result();
        results_seen++;
      end
      if (hold_req) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (pending.size() > TAIL_ITEMS && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_chan.ready <= rdy;
    end
  end

  // watchdog on handshake activity
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCH_MAX) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle = 0;
      else
        idle++;
    end
    $display("timeout: no handshake for %0d cycles", WATCH_MAX);
    $display("sorted_timeout_sleep_queue_tb: done, errors");
    $finish;
  end

  // stimulus, reset and end of run
  initial begin : main_flow
    sleep_cmd_t c;
    int  n_rand;
    int  sel;
    int  burst;
    int  j;
    rst_n = 1'b0;

    // directed: quiet tick, zero duration, fifo tie, deadline wrap
    pending.push_back(make_tick());
    pending.push_back(make_sleep(8'h00, 32'h0000_0000));
    pending.push_back(make_sleep(8'hFF, 32'h0000_0001));
    pending.push_back(make_sleep(8'h5A, 32'h0000_0001));
    pending.push_back(make_sleep(8'hA5, 32'hFFFF_FFFF));
    pending.push_back(make_tick());
    // directed: fill to the brim, reject, zero while full, wake all at once
    for (j = 0; j < DEPTH; j++)
      pending.push_back(make_sleep(tid_t'(j * 17 + 3), 32'h0000_0001));
    pending.push_back(make_sleep(8'h77, 32'h0000_0002));
    pending.push_back(make_sleep(8'h88, 32'h0000_0000));
    pending.push_back(make_tick());

    // random traffic: mostly short sleeps and ticks, some bursts and wraps
    n_rand = 0;
    while (n_rand < 235) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        pending.push_back(make_tick());
        n_rand++;
      end else if (sel >= 95) begin
        burst = $urandom_range(4, 12);
        for (j = 0; j < burst; j++)
          pending.push_back(make_sleep(tid_t'($urandom_range(0, 255)),
                                       tick_t'($urandom_range(1, 3))));
        n_rand += burst;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 10)
          c = make_sleep(tid_t'($urandom_range(0, 255)), '0);
        else if (sel < 18)
          c = make_sleep(tid_t'($urandom_range(0, 255)),
                         32'hFFFF_FFFF - tick_t'($urandom_range(0, 15)));
        else if (sel < 22)
          c = make_sleep(tid_t'($urandom_range(0, 255)), tick_t'($urandom));
        else
          c = make_sleep(tid_t'($urandom_range(0, 255)), tick_t'($urandom_range(1, 6)));
        pending.push_back(c);
        n_rand++;
      end
    end
    // receiver holds off long here; sender waits for a clean drain later
    pending[90].hold_rx = 1'b1;
    pending[170].drain  = 1'b1;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (!(pending.size() == 0 && !in_chan.valid && expected_results.size() == 0))
      @(posedge clk);
    repeat (40) @(posedge clk);

    $display("items %0d, results %0d: queued %0d, ignored %0d, full %0d, quiet %0d",
             items_taken, results_seen, n_queued, n_ignored, n_full, n_quiet);
    $display("threads woken %0d, most in one tick %0d, mismatches %0d",
             n_woken, peak_wakes, err_count);
    if (err_count == 0 && expected_results.size() == 0)
      $display("sorted_timeout_sleep_queue_tb: done, clean");
    else
      $display("sorted_timeout_sleep_queue_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/stsq_pkg.sv
hdl/stsq_if.sv
hdl/stsq_cell.sv
hdl/sorted_timeout_sleep_queue.sv
tb/sorted_timeout_sleep_queue_tb.sv
